>>> hdl/lpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared types and constants for the line position centroid block.
// ----------------------------------------------------------------------------
package lpc_pkg;

  localparam int NUM_SENSORS = 8;
  localparam int FULL_SCALE  = 1000;

  localparam int SAMPLE_W = 12;
  localparam int THRESH_W = 10;
  localparam int LEVEL_W  = 10;
  localparam int POS_W    = 13;
  localparam int NUM_W    = 22;
  localparam int DQ_W     = 10;
  localparam int TOTAL_W  = $clog2(NUM_SENSORS * FULL_SCALE + 1);
  localparam int WSUM_W   =
    $clog2(FULL_SCALE * FULL_SCALE * NUM_SENSORS * (NUM_SENSORS - 1) / 2 + 1);
  localparam int QP_W     = $clog2((NUM_SENSORS - 1) * FULL_SCALE + 1);

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_MIN    = 2'd0;
  localparam logic [1:0] REG_MAX    = 2'd1;
  localparam logic [1:0] REG_THRESH = 2'd2;

  localparam logic [SAMPLE_W-1:0] MIN_RESET    = 12'd0;
  localparam logic [SAMPLE_W-1:0] MAX_RESET    = 12'd4095;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 10'd200;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_0;
    logic [SAMPLE_W-1:0] sample_1;
    logic [SAMPLE_W-1:0] sample_2;
    logic [SAMPLE_W-1:0] sample_3;
    logic [SAMPLE_W-1:0] sample_4;
    logic [SAMPLE_W-1:0] sample_5;
    logic [SAMPLE_W-1:0] sample_6;
    logic [SAMPLE_W-1:0] sample_7;
  } in_t;

  typedef struct packed {
    logic             line_found;
    logic [POS_W-1:0] position;
  } out_t;

  typedef struct packed {
    logic                seen;
    logic [LEVEL_W-1:0]  level;
    logic [WSUM_W-1:0]   prod;
  } lane_res_t;

endpackage

>>> hdl/line_position_centroid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_position_centroid
// Weighted-centroid line position over one frame of reflectance samples.
// ----------------------------------------------------------------------------
// Usage: an item on the input channel (in_valid/in_ready/in_data) is one
// frame of eight raw samples. For every accepted item exactly one item
// appears on the result channel (out_valid/out_ready/out_data) with a found
// flag and a position in 0..7000. The APB-style port sets the shared white
// level, black level and detection threshold; it should be written only
// while no item is in flight.
// Throughput is one item per clock while the receiver does not stall.
// Between the accepting edge and the result lie the scaling multiply
// register, the per-lane normalizing divider, the lane weight multiply
// register, the merge adders, the centroid divider and the output register.
// The whole pipeline advances together; when the receiver holds out_ready
// low with a result waiting, every stage freezes and in_ready drops, so no
// item is lost or repeated.
// Reset empties the pipeline and loads min 0, max 4095 and threshold 200.
// ----------------------------------------------------------------------------
module line_position_centroid (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  lpc_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output lpc_pkg::out_t               out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lpc_pkg::ADDR_W-1:0]  paddr,
  input  logic [lpc_pkg::DATA_W-1:0]  pwdata,
  output logic [lpc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int N       = lpc_pkg::NUM_SENSORS;
  // Lane (12) + merge (1) + centroid divider + output register (1).
  localparam int LATENCY = 12 + 1 + lpc_pkg::QP_W + 1;

  // Configuration registers.
  logic [lpc_pkg::SAMPLE_W-1:0] min_level_r;
  logic [lpc_pkg::SAMPLE_W-1:0] max_level_r;
  logic [lpc_pkg::THRESH_W-1:0] thresh_r;
  logic                         wr_en;
  logic [1:0]                   reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_level_r <= lpc_pkg::MIN_RESET;
      max_level_r <= lpc_pkg::MAX_RESET;
      thresh_r    <= lpc_pkg::THRESH_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        lpc_pkg::REG_MIN:    min_level_r <= pwdata[lpc_pkg::SAMPLE_W-1:0];
        lpc_pkg::REG_MAX:    max_level_r <= pwdata[lpc_pkg::SAMPLE_W-1:0];
        lpc_pkg::REG_THRESH: thresh_r    <= pwdata[lpc_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lpc_pkg::REG_MIN:    prdata = lpc_pkg::DATA_W'(min_level_r);
      lpc_pkg::REG_MAX:    prdata = lpc_pkg::DATA_W'(max_level_r);
      lpc_pkg::REG_THRESH: prdata = lpc_pkg::DATA_W'(thresh_r);
      default:             prdata = '0;
    endcase
  end

  // Pipeline control: all stages move together whenever the output slot is
  // free or being emptied this cycle.
  logic               en;
  logic [LATENCY-1:0] vld_r;
  logic [LATENCY-1:0] vld_nxt;

  assign en       = !vld_r[LATENCY-1] || out_ready;
  assign in_ready = en;
  assign vld_nxt  = {vld_r[LATENCY-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // Sensor lanes.
  logic [lpc_pkg::SAMPLE_W-1:0] smp [N];
  lpc_pkg::lane_res_t           lane_res [N];

  assign smp[0] = in_data.sample_0;
  assign smp[1] = in_data.sample_1;
  assign smp[2] = in_data.sample_2;
  assign smp[3] = in_data.sample_3;
  assign smp[4] = in_data.sample_4;
  assign smp[5] = in_data.sample_5;
  assign smp[6] = in_data.sample_6;
  assign smp[7] = in_data.sample_7;

  for (genvar i = 0; i < N; i++) begin : g_lane
    lpc_lane #(
      .LANE_IDX (i)
    ) u_lane (
      .clk            (clk),
      .en             (en),
      .sample         (smp[i]),
      .min_level      (min_level_r),
      .max_level      (max_level_r),
      .line_threshold (thresh_r),
      .res            (lane_res[i])
    );
  end

  // Merge: weighted sum, level sum and the any-sensor-over-threshold flag.
  logic [lpc_pkg::WSUM_W-1:0]  wsum_nxt;
  logic [lpc_pkg::TOTAL_W-1:0] total_nxt;
  logic                        seen_nxt;
  logic [lpc_pkg::WSUM_W-1:0]  wsum_r;
  logic [lpc_pkg::TOTAL_W-1:0] total_r;
  logic                        found_r;

  always_comb begin
    wsum_nxt  = '0;
    total_nxt = '0;
    seen_nxt  = 1'b0;
    for (int i = 0; i < N; i++) begin
      wsum_nxt  = wsum_nxt + lane_res[i].prod;
      total_nxt = total_nxt + lpc_pkg::TOTAL_W'(lane_res[i].level);
      seen_nxt  = seen_nxt | lane_res[i].seen;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wsum_r  <= wsum_nxt;
      total_r <= total_nxt;
      found_r <= seen_nxt && (total_nxt != '0);
    end
  end

  // Centroid divider. When no line is found the dividend is forced to zero
  // and the divisor to one, so the quotient comes out as zero.
  logic [lpc_pkg::WSUM_W-1:0]  cdiv_num;
  logic [lpc_pkg::TOTAL_W-1:0] cdiv_den;
  logic [lpc_pkg::QP_W-1:0]    cquo;
  logic                        cfound;
  lpc_pkg::out_t               out_r;
  lpc_pkg::out_t               out_nxt;

  assign cdiv_num = found_r ? wsum_r : '0;
  assign cdiv_den = found_r ? total_r : lpc_pkg::TOTAL_W'(1);

  lpc_div #(
    .NW (lpc_pkg::WSUM_W),
    .DW (lpc_pkg::TOTAL_W),
    .QW (lpc_pkg::QP_W),
    .SW (1)
  ) u_cdiv (
    .clk      (clk),
    .en       (en),
    .num      (cdiv_num),
    .den      (cdiv_den),
    .side_in  (found_r),
    .quo      (cquo),
    .side_out (cfound)
  );

  always_comb begin
    out_nxt.line_found = cfound;
    out_nxt.position   = cquo[lpc_pkg::POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = vld_r[LATENCY-1];
  assign out_data  = out_r;

endmodule

>>> hdl/lpc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module lpc_div #(
  parameter int NW = 22,
  parameter int DW = 12,
  parameter int QW = 10,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] side_out
);

  // The quotient must fit in QW bits: num < den * 2**QW.
  localparam int W = NW + DW + QW;

  logic [NW-1:0] rem_r  [QW];
  logic [DW-1:0] den_r  [QW];
  logic [QW-1:0] quo_r  [QW];
  logic [SW-1:0] side_r [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;
    logic [NW-1:0] rem_prev;
    logic [DW-1:0] den_prev;
    logic [QW-1:0] quo_prev;
    logic [SW-1:0] side_prev;
    logic [W-1:0]  rem_x;
    logic [W-1:0]  sub_x;
    logic          ge;
    logic [NW-1:0] rem_nxt;
    logic [QW-1:0] quo_nxt;

    if (s == 0) begin : g_first
      assign rem_prev  = num;
      assign den_prev  = den;
      assign quo_prev  = '0;
      assign side_prev = side_in;
    end else begin : g_next
      assign rem_prev  = rem_r[s-1];
      assign den_prev  = den_r[s-1];
      assign quo_prev  = quo_r[s-1];
      assign side_prev = side_r[s-1];
    end

    assign rem_x   = W'(rem_prev);
    assign sub_x   = W'(den_prev) << B;
    assign ge      = (rem_x >= sub_x);
    assign rem_nxt = ge ? NW'(rem_x - sub_x) : rem_prev;
    assign quo_nxt = ge ? (quo_prev | (QW'(1) << B)) : quo_prev;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        den_r[s]  <= den_prev;
        quo_r[s]  <= quo_nxt;
        side_r[s] <= side_prev;
      end
    end
  end

  assign quo      = quo_r[QW-1];
  assign side_out = side_r[QW-1];

endmodule

>>> hdl/lpc_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_lane
// One sensor lane: normalizes a raw sample to 0..1000 and weights it.
// ----------------------------------------------------------------------------
module lpc_lane #(
  parameter int LANE_IDX = 0
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [lpc_pkg::SAMPLE_W-1:0]  sample,
  input  logic [lpc_pkg::SAMPLE_W-1:0]  min_level,
  input  logic [lpc_pkg::SAMPLE_W-1:0]  max_level,
  input  logic [lpc_pkg::THRESH_W-1:0]  line_threshold,
  output lpc_pkg::lane_res_t            res
);

  localparam int WEIGHT = LANE_IDX * lpc_pkg::FULL_SCALE;

  logic [lpc_pkg::SAMPLE_W-1:0] span;
  logic [lpc_pkg::SAMPLE_W-1:0] diff;
  logic [lpc_pkg::NUM_W-1:0]    num;
  logic                         sat;
  logic                         zero;
  logic [lpc_pkg::NUM_W-1:0]    num_r;
  logic                         sat_r;
  logic                         zero_r;
  logic [lpc_pkg::NUM_W-1:0]    div_num;
  logic [lpc_pkg::DQ_W-1:0]     quo;
  logic [1:0]                   flags;
  logic [lpc_pkg::LEVEL_W-1:0]  level;
  lpc_pkg::lane_res_t           res_r;
  lpc_pkg::lane_res_t           res_nxt;

  assign span = max_level - min_level;
  assign diff = sample - min_level;
  assign num  = lpc_pkg::NUM_W'(diff) * lpc_pkg::NUM_W'(lpc_pkg::FULL_SCALE);
  // A quotient of 1024 or more saturates anyway, so the divider needs 10 bits.
  assign sat  = (num >= lpc_pkg::NUM_W'({span, {lpc_pkg::DQ_W{1'b0}}}));
  assign zero = (max_level <= min_level) || (sample <= min_level);

  always_ff @(posedge clk) begin
    if (en) begin
      num_r  <= num;
      sat_r  <= sat;
      zero_r <= zero;
    end
  end

  assign div_num = (sat_r || zero_r) ? '0 : num_r;

  lpc_div #(
    .NW (lpc_pkg::NUM_W),
    .DW (lpc_pkg::SAMPLE_W),
    .QW (lpc_pkg::DQ_W),
    .SW (2)
  ) u_div (
    .clk      (clk),
    .en       (en),
    .num      (div_num),
    .den      (span),
    .side_in  ({sat_r, zero_r}),
    .quo      (quo),
    .side_out (flags)
  );

  always_comb begin
    if (flags[0]) begin
      level = '0;
    end else if (flags[1] || (quo > lpc_pkg::DQ_W'(lpc_pkg::FULL_SCALE))) begin
      level = lpc_pkg::LEVEL_W'(lpc_pkg::FULL_SCALE);
    end else begin
      level = quo;
    end
    res_nxt.level = level;
    res_nxt.seen  = (level > line_threshold);
    res_nxt.prod  = lpc_pkg::WSUM_W'(level) * lpc_pkg::WSUM_W'(WEIGHT);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

>>> hdl/lpc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_checker
// Port-level assertions for the line position centroid block.
// ----------------------------------------------------------------------------
module lpc_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          out_valid,
  input  logic          out_ready,
  input  lpc_pkg::out_t out_data
);

  localparam logic [lpc_pkg::POS_W-1:0] MAX_POS =
    lpc_pkg::POS_W'((lpc_pkg::NUM_SENSORS - 1) * lpc_pkg::FULL_SCALE);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.line_found |-> out_data.position == '0)
    else $error("position nonzero without a line");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.position <= MAX_POS)
    else $error("position beyond the last sensor");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item present right after reset");

endmodule

bind line_position_centroid lpc_checker u_lpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> tb/sv/lpc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_scoreboard
// Watches both channels and the register port of the centroid block, works
// out the expected found flag and position of every accepted frame, and
// compares each delivered result with the oldest one waiting.
// ----------------------------------------------------------------------------
module lpc_scoreboard (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  lpc_pkg::in_t                in_data,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  lpc_pkg::out_t               out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [lpc_pkg::ADDR_W-1:0]  paddr,
  input  logic [lpc_pkg::DATA_W-1:0]  pwdata,
  output int                          fail_count,
  output int                          pending
);

  logic [lpc_pkg::SAMPLE_W-1:0] white_lvl;
  logic [lpc_pkg::SAMPLE_W-1:0] black_lvl;
  logic [lpc_pkg::THRESH_W-1:0] thresh_lvl;
  lpc_pkg::out_t                centroid_q[$];

  function automatic int unsigned scale_level(logic [lpc_pkg::SAMPLE_W-1:0] raw);
    int unsigned lvl;
    if (black_lvl <= white_lvl || raw <= white_lvl) return 0;
    lvl = ((raw - white_lvl) * lpc_pkg::FULL_SCALE) / (black_lvl - white_lvl);
    return (lvl > lpc_pkg::FULL_SCALE) ? lpc_pkg::FULL_SCALE : lvl;
  endfunction

  function automatic lpc_pkg::out_t locate_line(lpc_pkg::in_t frame);
    logic [lpc_pkg::SAMPLE_W-1:0] raw[lpc_pkg::NUM_SENSORS];
    longint unsigned wsum;
    longint unsigned tot;
    int unsigned lvl;
    bit seen;
    lpc_pkg::out_t res;
    raw = '{frame.sample_0, frame.sample_1, frame.sample_2, frame.sample_3,
            frame.sample_4, frame.sample_5, frame.sample_6, frame.sample_7};
    wsum = 0;
    tot  = 0;
    seen = 0;
    for (int i = 0; i < lpc_pkg::NUM_SENSORS; i++) begin
      lvl = scale_level(raw[i]);
      if (lvl > thresh_lvl) seen = 1;
      wsum += longint'(lvl) * i * lpc_pkg::FULL_SCALE;
      tot  += lvl;
    end
    res = '0;
    if (seen && tot != 0) begin
      res.line_found = 1'b1;
      res.position   = lpc_pkg::POS_W'(wsum / tot);
    end
    return res;
  endfunction

  assign pending = centroid_q.size();

  always @(posedge clk) begin
    lpc_pkg::out_t want;
    if (!rst_n) begin
      white_lvl  <= lpc_pkg::MIN_RESET;
      black_lvl  <= lpc_pkg::MAX_RESET;
      thresh_lvl <= lpc_pkg::THRESH_RESET;
      fail_count <= 0;
      centroid_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          lpc_pkg::REG_MIN:    white_lvl  <= pwdata[lpc_pkg::SAMPLE_W-1:0];
          lpc_pkg::REG_MAX:    black_lvl  <= pwdata[lpc_pkg::SAMPLE_W-1:0];
          lpc_pkg::REG_THRESH: thresh_lvl <= pwdata[lpc_pkg::THRESH_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) centroid_q.push_back(locate_line(in_data));
      if (out_valid && out_ready) begin
        if (centroid_q.size() == 0) begin
          $display("%0t: expected no item, actual found=%0d pos=%0d", $time,
                   out_data.line_found, out_data.position);
          fail_count <= fail_count + 1;
        end else begin
          want = centroid_q.pop_front();
          if (want.line_found !== out_data.line_found) begin
            $display("%0t: line_found expected %0d actual %0d", $time,
                     want.line_found, out_data.line_found);
            fail_count <= fail_count + 1;
          end else if (want.position !== out_data.position) begin
            $display("%0t: position expected %0d actual %0d", $time,
                     want.position, out_data.position);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives sensor frames and register settings into the centroid block under
// random idling on both sides; the checker judges every result.
// ----------------------------------------------------------------------------
module testbench;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  lpc_pkg::in_t                in_data = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  lpc_pkg::out_t               out_data;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [lpc_pkg::ADDR_W-1:0]  paddr = '0;
  logic [lpc_pkg::DATA_W-1:0]  pwdata = '0;
  logic [lpc_pkg::DATA_W-1:0]  prdata;
  logic                        pready;
  int   fail_count;
  int   pending;
  // Percent chances that the sender idles and the receiver stalls in a cycle.
  int   send_idle = 0;
  int   recv_stall = 0;
  // Current white and black levels, so frames can be aimed around the band.
  int   cur_white = 0;
  int   cur_black = 4095;

  always #6 clk = ~clk;

  line_position_centroid dut (.*);

  lpc_scoreboard checker_i (.*);

  // The receiver stalls on its own at the chosen rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  // Register write: setup, then access.
  task automatic write_reg(logic [1:0] idx, int val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= lpc_pkg::ADDR_W'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == lpc_pkg::REG_MIN) cur_white = val;
    if (idx == lpc_pkg::REG_MAX) cur_black = val;
  endtask

  // Offers one frame and holds it until the block takes it. Called just
  // after a rising edge; valid stays high on return so the next frame can
  // follow at once; it drops when the sender chooses to idle or the bench waits for the pipeline to empty.
  task automatic send_frame(lpc_pkg::in_t frame);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= frame;
    do @(posedge clk); while (!in_ready);
  endtask

  // Raw value picked near the current band so both ends and the middle
  // are all reached, with some fully random values mixed in.
  function automatic logic [lpc_pkg::SAMPLE_W-1:0] pick_raw();
    int lo;
    int hi;
    lo = (cur_white < cur_black) ? cur_white : cur_black;
    hi = (cur_white < cur_black) ? cur_black : cur_white;
    case ($urandom_range(5))
      0: return lpc_pkg::SAMPLE_W'($urandom);
      1: return lpc_pkg::SAMPLE_W'(lo);
      2: return lpc_pkg::SAMPLE_W'(hi);
      default: return lpc_pkg::SAMPLE_W'($urandom_range(hi, lo));
    endcase
  endfunction

  // A line under the frame: one or a few adjacent sensors dark, rest picked freely; or a fully random frame.
  function automatic lpc_pkg::in_t line_frame();
    logic [lpc_pkg::SAMPLE_W-1:0] s[lpc_pkg::NUM_SENSORS];
    int c;
    int w;
    c = $urandom_range(lpc_pkg::NUM_SENSORS - 1);
    w = $urandom_range(2);
    for (int i = 0; i < lpc_pkg::NUM_SENSORS; i++)
      s[i] = (i >= c - w && i <= c + w) ? pick_raw() | 12'hC00 : pick_raw();
    if ($urandom_range(2) == 0)
      for (int i = 0; i < lpc_pkg::NUM_SENSORS; i++) s[i] = pick_raw();
    return {s[0], s[1], s[2], s[3], s[4], s[5], s[6], s[7]};
  endfunction

  // Drops valid, waits until every result is back, then waits longer than the
  // pipeline depth.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    int settings[6][3];
    settings = '{'{0, 4095, 200}, '{4095, 0, 0}, '{100, 3000, 1000},
                 '{2000, 2001, 0}, '{500, 500, 500}, '{1000, 3500, 512}};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames at reset settings: all white, all black (every bit set), single spots,
    // alternating bit patterns, and uniform frames at the threshold level.
    send_frame('0);
    send_frame('1);
    for (int i = 0; i < lpc_pkg::NUM_SENSORS; i++)
      send_frame(lpc_pkg::in_t'({12'hFFF,
        {(lpc_pkg::NUM_SENSORS-1)*lpc_pkg::SAMPLE_W{1'b0}}} >> (i*lpc_pkg::SAMPLE_W)));
    send_frame({lpc_pkg::NUM_SENSORS{12'hAAA}});
    send_frame({lpc_pkg::NUM_SENSORS{12'h555}});
    send_frame({lpc_pkg::NUM_SENSORS{12'd819}});
    send_frame({lpc_pkg::NUM_SENSORS{12'd820}});
    drain();
    // Threshold at and above full scale, and a collapsed span.
    write_reg(lpc_pkg::REG_THRESH, 1000);
    send_frame('1);
    drain();
    write_reg(lpc_pkg::REG_THRESH, 1023);
    send_frame('1);
    drain();
    write_reg(lpc_pkg::REG_MIN, 4095);
    write_reg(lpc_pkg::REG_MAX, 0);
    write_reg(lpc_pkg::REG_THRESH, 0);
    send_frame('1);
    send_frame('0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(lpc_pkg::REG_MIN, settings[ph][0]);
      write_reg(lpc_pkg::REG_MAX, settings[ph][1]);
      write_reg(lpc_pkg::REG_THRESH, settings[ph][2]);
      for (int k = 0; k < 225; k++) begin
        case (k / 56)
          0: begin send_idle = 0;  recv_stall = 0;  end
          1: begin send_idle = 69; recv_stall = 0;  end
          2: begin send_idle = 0;  recv_stall = 69; end
          default: begin send_idle = 35; recv_stall = 35; end
        endcase
        if (k == 100) begin
          // Let the pipeline empty completely before going on.
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        send_frame(line_frame());
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("line_position_centroid: match");
    end else begin
      $display("line_position_centroid: mismatch");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("line_position_centroid: mismatch");
    $finish;
  end
endmodule
